@@ sv/modbus_tcp_write_registers_slave_assert.svh @@
// assertion macros used by the checker file of the modbus write-registers slave
// no dependencies; included by bare file name
`ifndef MODBUS_TCP_WRITE_REGISTERS_SLAVE_ASSERT_SVH
`define MODBUS_TCP_WRITE_REGISTERS_SLAVE_ASSERT_SVH

// same-cycle implication
`define MTW_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtw assertion failed");

// next-cycle implication
`define MTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtw assertion failed");

`endif

@@ sv/mtw_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the modbus tcp write-registers slave
// no dependencies
package mtw_pkg;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_in_t;

  typedef struct packed {
    logic [7:0] response_byte;
    logic       response_last;
  } resp_out_t;

  // header fields of a checked frame handed from the parser to the executor
  typedef struct packed {
    logic [7:0]  tid_hi;
    logic [7:0]  tid_lo;
    logic [7:0]  func;
    logic [15:0] start;
    logic [15:0] qty;
    logic [7:0]  byte_cnt;
  } job_t;

  localparam int unsigned HDR_LEN = 13;
  localparam int unsigned MIN_FRAME = 8;
  localparam int unsigned MBAP_LEN = 6;

  localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
  localparam logic [7:0] EXC_FLAG = 8'h80;

  localparam logic [2:0] EXC_NONE = 3'd0;
  localparam logic [2:0] EXC_ILLEGAL_FUNC = 3'd1;
  localparam logic [2:0] EXC_ILLEGAL_ADDR = 3'd2;
  localparam logic [2:0] EXC_ILLEGAL_QTY = 3'd3;
  localparam logic [2:0] EXC_ILLEGAL_VALUE = 3'd4;

  localparam logic [3:0] RESP_LEN_OK = 4'd12;
  localparam logic [3:0] RESP_LEN_EXC = 4'd9;

  localparam logic [1:0] REG_UNIT_ID = 2'd0;
  localparam logic [1:0] REG_FIRST_ADDR = 2'd1;
  localparam logic [1:0] REG_VALUE_LIMIT = 2'd2;

  localparam logic [7:0] UNIT_ID_RST = 8'd1;
  localparam logic [15:0] FIRST_ADDR_RST = 16'h0010;
  localparam logic [15:0] VALUE_LIMIT_RST = 16'd1023;

endpackage

@@ sv/mtw_front.sv @@
`timescale 1ns / 1ps
// frame parser: takes request bytes, stores header and data words, checks the frame
// depends on mtw_pkg
module mtw_front #(
  parameter int unsigned NUM_REGISTERS = 8,
  parameter int unsigned MAX_FRAME = 260
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [7:0]                          unit_id_i,
  input  logic                                byte_valid_i,
  input  mtw_pkg::frame_in_t                  byte_data_i,
  input  logic                                job_full_i,
  output logic                                byte_ready_o,
  output logic                                job_push_o,
  output mtw_pkg::job_t                       job_o,
  output logic [NUM_REGISTERS-1:0][15:0]      values_o
);

  localparam int unsigned IW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
  localparam logic [8:0] MaxFrame = 9'(MAX_FRAME);
  localparam logic [8:0] HdrLen = 9'(mtw_pkg::HDR_LEN);
  localparam logic [8:0] StageEnd = 9'(mtw_pkg::HDR_LEN + 2 * NUM_REGISTERS);
  localparam logic [9:0] MinFrame = 10'(mtw_pkg::MIN_FRAME);
  localparam logic [15:0] MbapLen = 16'(mtw_pkg::MBAP_LEN);

  logic [8:0]                     cnt_q, cnt_d;
  logic                           too_long_q, too_long_d;
  logic [12:0][7:0]               hdr_q, hdr_d;
  logic [NUM_REGISTERS-1:0][15:0] stg_q, stg_d;
  logic [8:0]                     off;
  logic [IW-1:0]                  word;
  logic [9:0]                     len;
  logic                           drop;
  logic                           take;

  assign byte_ready_o = !job_full_i;
  assign take = byte_valid_i && byte_ready_o;
  assign off = cnt_q - HdrLen;
  assign word = off[IW:1];
  assign len = {1'b0, cnt_q} + 10'd1;

  // header and staging as they stand after this byte
  always_comb begin
    hdr_d = hdr_q;
    stg_d = stg_q;
    too_long_d = too_long_q || (cnt_q >= MaxFrame);
    if (cnt_q < HdrLen) begin
      hdr_d[cnt_q[3:0]] = byte_data_i.frame_byte;
    end else if (cnt_q < StageEnd) begin
      if (off[0]) begin
        stg_d[word][7:0] = byte_data_i.frame_byte;
      end else begin
        stg_d[word][15:8] = byte_data_i.frame_byte;
      end
    end
    cnt_d = (cnt_q == 9'h1FF) ? cnt_q : cnt_q + 9'd1;
  end

  assign drop = too_long_d || (len < MinFrame) || (hdr_d[2] != 8'h00) ||
                (hdr_d[3] != 8'h00) || (hdr_d[6] != unit_id_i) ||
                ({hdr_d[4], hdr_d[5]} != ({6'b0, len} - MbapLen));

  assign job_push_o = take && byte_data_i.frame_last && !drop;
  assign job_o.tid_hi = hdr_d[0];
  assign job_o.tid_lo = hdr_d[1];
  assign job_o.func = hdr_d[7];
  assign job_o.start = {hdr_d[8], hdr_d[9]};
  assign job_o.qty = {hdr_d[10], hdr_d[11]};
  assign job_o.byte_cnt = hdr_d[12];
  assign values_o = stg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      too_long_q <= 1'b0;
      hdr_q <= '0;
      stg_q <= '0;
    end else if (take) begin
      if (byte_data_i.frame_last) begin
        cnt_q <= '0;
        too_long_q <= 1'b0;
        hdr_q <= '0;
        stg_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        too_long_q <= too_long_d;
        hdr_q <= hdr_d;
        stg_q <= stg_d;
      end
    end
  end

endmodule

@@ sv/mtw_fifo.sv @@
`timescale 1ns / 1ps
// small job queue between the frame parser and the executor
// no dependencies
module mtw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW:0] Depth = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LastSlot = PW'(DEPTH - 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PW-1:0]               wr_q, rd_q;
  logic [PW:0]                 cnt_q;
  logic                        do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == Depth);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastSlot) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastSlot) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PW + 1)'(1);
      end
    end
  end

endmodule

@@ sv/mtw_back.sv @@
`timescale 1ns / 1ps
// executor: checks the write request, scans the data words, writes the register file, sends the response
// depends on mtw_pkg
module mtw_back #(
  parameter int unsigned NUM_REGISTERS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [7:0]                     unit_id_i,
  input  logic [15:0]                    first_address_i,
  input  logic [15:0]                    value_limit_i,
  input  logic                           job_empty_i,
  input  mtw_pkg::job_t                  job_i,
  input  logic [NUM_REGISTERS-1:0][15:0] values_i,
  output logic                           job_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mtw_pkg::resp_out_t             out_data_o
);

  localparam int unsigned IW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
  localparam int unsigned CW = $clog2(NUM_REGISTERS + 1);
  localparam logic [15:0] NumRegs = 16'(NUM_REGISTERS);
  localparam logic [16:0] NumRegsW = 17'(NUM_REGISTERS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [2:0]                     state_q;
  logic [2:0]                     code_q;
  logic [2:0]                     code_d;
  logic [IW-1:0]                  base_q;
  logic [CW-1:0]                  idx_q;
  logic [3:0]                     k_q;
  logic [NUM_REGISTERS-1:0][15:0] regfile_q;
  logic                           out_valid_q;
  mtw_pkg::resp_out_t             out_data_q;

  logic [16:0]   top;
  logic          qty_ok, bc_ok, addr_ok;
  logic [15:0]   base_full;
  logic [CW-1:0] qty_last;
  logic [15:0]   cur_val;
  logic [IW-1:0] wr_idx;
  logic [3:0]    resp_len;
  logic [7:0]    resp_byte;
  logic          resp_last;
  logic          load;

  // request checks, evaluated on the queue head
  assign top = {1'b0, first_address_i} + NumRegsW;
  assign qty_ok = (job_i.qty != 16'd0) && (job_i.qty <= NumRegs);
  assign bc_ok = ({1'b0, job_i.byte_cnt} == {job_i.qty[7:0], 1'b0});
  assign addr_ok = (job_i.start >= first_address_i) &&
                   ({1'b0, job_i.start} <= top - 17'd1) &&
                   (({1'b0, job_i.start} + {1'b0, job_i.qty}) <= top);
  assign base_full = job_i.start - first_address_i;

  always_comb begin
    if (job_i.func != mtw_pkg::FUNC_WRITE_MULTI) begin
      code_d = mtw_pkg::EXC_ILLEGAL_FUNC;
    end else if (!qty_ok || !bc_ok) begin
      code_d = mtw_pkg::EXC_ILLEGAL_QTY;
    end else if (!addr_ok) begin
      code_d = mtw_pkg::EXC_ILLEGAL_ADDR;
    end else begin
      code_d = mtw_pkg::EXC_NONE;
    end
  end

  assign qty_last = job_i.qty[CW-1:0] - CW'(1);
  assign cur_val = values_i[idx_q[IW-1:0]];
  assign wr_idx = base_q + idx_q[IW-1:0];

  assign resp_len = (code_q == mtw_pkg::EXC_NONE) ? mtw_pkg::RESP_LEN_OK
                                                  : mtw_pkg::RESP_LEN_EXC;
  assign resp_last = (k_q == resp_len - 4'd1);

  always_comb begin
    case (k_q)
      4'd0: resp_byte = job_i.tid_hi;
      4'd1: resp_byte = job_i.tid_lo;
      4'd5: resp_byte = {4'b0, resp_len} - 8'(mtw_pkg::MBAP_LEN);
      4'd6: resp_byte = unit_id_i;
      4'd7: resp_byte = (code_q == mtw_pkg::EXC_NONE) ? mtw_pkg::FUNC_WRITE_MULTI
                                                      : (job_i.func | mtw_pkg::EXC_FLAG);
      4'd8: resp_byte = (code_q == mtw_pkg::EXC_NONE) ? job_i.start[15:8]
                                                      : {5'b0, code_q};
      4'd9: resp_byte = job_i.start[7:0];
      4'd10: resp_byte = job_i.qty[15:8];
      4'd11: resp_byte = job_i.qty[7:0];
      default: resp_byte = 8'h00;
    endcase
  end

  assign load = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign job_pop_o = load && resp_last;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.response_byte <= resp_byte;
      out_data_q.response_last <= resp_last;
    end
    if (state_q == ST_IDLE) begin
      code_q <= code_d;
      base_q <= base_full[IW-1:0];
    end else if (state_q == ST_SCAN && cur_val > value_limit_i) begin
      code_q <= mtw_pkg::EXC_ILLEGAL_VALUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q <= '0;
      k_q <= '0;
      out_valid_q <= 1'b0;
      regfile_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !load) begin
        out_valid_q <= 1'b0;
      end else if (load) begin
        out_valid_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          k_q <= '0;
          if (!job_empty_i) begin
            state_q <= (code_d == mtw_pkg::EXC_NONE) ? ST_SCAN : ST_EMIT;
          end
        end
        ST_SCAN: begin
          if (cur_val > value_limit_i) begin
            state_q <= ST_EMIT;
          end else if (idx_q == qty_last) begin
            idx_q <= '0;
            state_q <= ST_WRITE;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        ST_WRITE: begin
          regfile_q[wr_idx] <= cur_val;
          if (idx_q == qty_last) begin
            state_q <= ST_EMIT;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        ST_EMIT: begin
          if (load) begin
            if (resp_last) begin
              state_q <= ST_IDLE;
            end else begin
              k_q <= k_q + 4'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sv/modbus_tcp_write_registers_slave.sv @@
`timescale 1ns / 1ps
// request bytes: one per cycle; the parser stalls only when both job queue slots are taken
// per write the executor checks the request while idle, then scans and writes the qty entries,
// one entry a cycle; a failed check skips both, a value over the limit ends the scan; then 9 or 12 bytes
// reset: asynchronous, active low; clears config to defaults, the register file and the queue
// depends on mtw_pkg, mtw_front, mtw_fifo, mtw_back
module modbus_tcp_write_registers_slave #(
  parameter int unsigned NUM_REGISTERS = 8,
  parameter int unsigned MAX_FRAME = 260
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mtw_pkg::frame_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mtw_pkg::resp_out_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned JW = $bits(mtw_pkg::job_t) + 16 * NUM_REGISTERS;

  logic [7:0]  unit_id_q;
  logic [15:0] first_addr_q;
  logic [15:0] value_limit_q;
  logic        wr_en;

  logic                           push, pop, q_empty, q_full;
  mtw_pkg::job_t                  job_in, job_out;
  logic [NUM_REGISTERS-1:0][15:0] vals_in, vals_out;
  logic [JW-1:0]                  q_head;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_id_q <= mtw_pkg::UNIT_ID_RST;
      first_addr_q <= mtw_pkg::FIRST_ADDR_RST;
      value_limit_q <= mtw_pkg::VALUE_LIMIT_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        mtw_pkg::REG_UNIT_ID: unit_id_q <= pwdata[7:0];
        mtw_pkg::REG_FIRST_ADDR: first_addr_q <= pwdata[15:0];
        mtw_pkg::REG_VALUE_LIMIT: value_limit_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mtw_pkg::REG_UNIT_ID: prdata = {24'b0, unit_id_q};
      mtw_pkg::REG_FIRST_ADDR: prdata = {16'b0, first_addr_q};
      mtw_pkg::REG_VALUE_LIMIT: prdata = {16'b0, value_limit_q};
      default: prdata = '0;
    endcase
  end

  mtw_front #(
    .NUM_REGISTERS(NUM_REGISTERS),
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .unit_id_i   (unit_id_q),
    .byte_valid_i(in_valid_i),
    .byte_data_i (in_data_i),
    .job_full_i  (q_full),
    .byte_ready_o(in_ready_o),
    .job_push_o  (push),
    .job_o       (job_in),
    .values_o    (vals_in)
  );

  mtw_fifo #(
    .WIDTH(JW),
    .DEPTH(2)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({vals_in, job_in}),
    .pop_i  (pop),
    .data_o (q_head),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  assign {vals_out, job_out} = q_head;

  mtw_back #(
    .NUM_REGISTERS(NUM_REGISTERS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .unit_id_i      (unit_id_q),
    .first_address_i(first_addr_q),
    .value_limit_i  (value_limit_q),
    .job_empty_i    (q_empty),
    .job_i          (job_out),
    .values_i       (vals_out),
    .job_pop_o      (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule

@@ sv/mtw_checker.sv @@
`timescale 1ns / 1ps
// port-level checker for the modbus write-registers slave, bound to the top level
// depends on mtw_pkg and modbus_tcp_write_registers_slave_assert.svh
`include "modbus_tcp_write_registers_slave_assert.svh"

module mtw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mtw_pkg::resp_out_t out_data_o,
  input logic               pready
);

  logic [3:0] pos_q;
  logic       out_wait;
  logic       out_last;
  logic       zero_pos;

  // byte position inside the current response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      pos_q <= out_data_o.response_last ? 4'd0 : pos_q + 4'd1;
    end
  end

  assign out_wait = out_valid_o && !out_ready_i;
  assign out_last = out_valid_o && out_data_o.response_last;
  assign zero_pos = out_valid_o && (pos_q == 4'd2 || pos_q == 4'd3 || pos_q == 4'd4);

  `MTW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_data_o))
  `MTW_ASSERT_IMPLY(a_last_pos, clk_i, rst_ni, out_last, pos_q == 4'd8 || pos_q == 4'd11)
  `MTW_ASSERT_IMPLY(a_zero_hdr, clk_i, rst_ni, zero_pos, out_data_o.response_byte == 8'h00)
  `MTW_ASSERT_IMPLY(a_no_overrun, clk_i, rst_ni, out_valid_o, pos_q <= 4'd11)
  `MTW_ASSERT_IMPLY(a_pready, clk_i, rst_ni, 1'b1, pready)

endmodule

bind modbus_tcp_write_registers_slave mtw_checker u_mtw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o),
  .pready     (pready)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for the modbus tcp write-multiple-registers slave: builds request
// frames byte by byte, predicts every response byte and checks them in order
// depends on mtw_pkg and modbus_tcp_write_registers_slave
import mtw_pkg::*;

class modbus_reply_tracker #(int unsigned NREG = 8, int unsigned MAXF = 260);
  logic [7:0]  unit_id_q;
  logic [15:0] base_addr;
  logic [15:0] value_cap;

  int unsigned rx_count;
  bit          overrun;
  logic [7:0]  hdr[HDR_LEN];
  logic [15:0] staged[NREG];
  logic [15:0] regs[NREG];

  resp_out_t   replies_due[$];
  int unsigned mismatches;
  int unsigned bytes_checked;
  int unsigned frames_dropped;
  int unsigned answers_by_code[8];

  function new();
    unit_id_q = UNIT_ID_RST;
    base_addr = FIRST_ADDR_RST;
    value_cap = VALUE_LIMIT_RST;
    foreach (regs[k]) regs[k] = '0;
    clear_frame();
  endfunction

  function void set_register(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_UNIT_ID: unit_id_q = val[7:0];
      REG_FIRST_ADDR: base_addr = val[15:0];
      REG_VALUE_LIMIT: value_cap = val[15:0];
      default: ;
    endcase
  endfunction

  function void clear_frame();
    rx_count = 0;
    overrun = 1'b0;
    foreach (hdr[k]) hdr[k] = '0;
    foreach (staged[k]) staged[k] = '0;
  endfunction

  function int unsigned field16(int unsigned pos);
    return 32'({hdr[pos], hdr[pos + 1]});
  endfunction

  // checks and commits a write request, returns the exception code
  function logic [2:0] apply_write();
    int unsigned qty, start, top, k;
    qty = field16(10);
    start = field16(8);
    top = base_addr + NREG;
    if (qty < 1 || qty > NREG) return EXC_ILLEGAL_QTY;
    if (hdr[12] != qty * 2) return EXC_ILLEGAL_QTY;
    if (start < base_addr || start > top - 1) return EXC_ILLEGAL_ADDR;
    if (start + qty > top) return EXC_ILLEGAL_ADDR;
    for (k = 0; k < qty; k++)
      if (staged[k] > value_cap) return EXC_ILLEGAL_VALUE;
    for (k = 0; k < qty; k++) regs[start - base_addr + k] = staged[k];
    return EXC_NONE;
  endfunction

  function void absorb_request_byte(frame_in_t it);
    int unsigned pos, len, n, k, off;
    logic [2:0]  code;
    logic [7:0]  reply[12];
    resp_out_t   r;
    pos = rx_count;
    if (pos >= MAXF) overrun = 1'b1;
    if (pos < HDR_LEN) begin
      hdr[pos] = it.frame_byte;
    end else if (pos < HDR_LEN + 2 * NREG) begin
      off = pos - HDR_LEN;
      if (off[0]) staged[off >> 1][7:0] = it.frame_byte;
      else staged[off >> 1][15:8] = it.frame_byte;
    end
    if (rx_count < 511) rx_count++;
    if (!it.frame_last) return;

    len = pos + 1;
    if (overrun || len < MIN_FRAME || hdr[2] != 0 || hdr[3] != 0 || hdr[6] != unit_id_q ||
        field16(4) != len - MBAP_LEN) begin
      frames_dropped++;
      clear_frame();
      return;
    end

    code = (hdr[7] == FUNC_WRITE_MULTI) ? apply_write() : EXC_ILLEGAL_FUNC;
    reply[0] = hdr[0];
    reply[1] = hdr[1];
    reply[2] = 8'h00;
    reply[3] = 8'h00;
    reply[6] = unit_id_q;
    if (code == EXC_NONE) begin
      reply[7] = FUNC_WRITE_MULTI;
      for (k = 8; k < 12; k++) reply[k] = hdr[k];
      n = RESP_LEN_OK;
    end else begin
      reply[7] = hdr[7] | EXC_FLAG;
      reply[8] = {5'd0, code};
      n = RESP_LEN_EXC;
    end
    reply[4] = 8'h00;
    reply[5] = 8'(n - MBAP_LEN);
    for (k = 0; k < n; k++) begin
      r.response_byte = reply[k];
      r.response_last = (k == n - 1);
      replies_due.push_back(r);
    end
    answers_by_code[code]++;
    clear_frame();
  endfunction

  function void check_response_byte(resp_out_t got);
    resp_out_t want;
    if (replies_due.size() == 0) begin
      $display("%0t: unexpected response byte %h last %b", $time,
               got.response_byte, got.response_last);
      mismatches++;
      return;
    end
    want = replies_due.pop_front();
    if (got.response_byte !== want.response_byte) begin
      $display("%0t: response_byte expected %h actual %h", $time,
               want.response_byte, got.response_byte);
      mismatches++;
    end
    if (got.response_last !== want.response_last) begin
      $display("%0t: response_last expected %b actual %b", $time,
               want.response_last, got.response_last);
      mismatches++;
    end
    bytes_checked++;
  endfunction

  function int pending();
    return replies_due.size();
  endfunction
endclass

module testbench;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned MAX_FRAME_LEN = 260;
  localparam int RANDOM_BYTES = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {FLOW_FREE, FLOW_SPARSE, FLOW_HEAVY} flow_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  frame_in_t   in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  resp_out_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  modbus_reply_tracker #(NUM_REGS, MAX_FRAME_LEN) replies;
  frame_in_t   req_q[$];
  logic [7:0]  frame_buf[$];
  bit          hold_request = 1'b0;
  int          config_errors = 0;
  int          sent_bytes = 0;
  int          frames_built = 0;
  int          settings_run = 0;
  int          cycle_count = 0;

  modbus_tcp_write_registers_slave #(
    .NUM_REGISTERS(NUM_REGS),
    .MAX_FRAME(MAX_FRAME_LEN)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d response bytes outstanding", $time, replies.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) replies.check_response_byte(out_data_o);
  end

  // response side: random stall pattern, plus one long hold-off on request
  initial begin
    int stall_left, hold_left, epoch;
    flow_mode_e mode;
    stall_left = 0;
    hold_left = 0;
    epoch = 0;
    mode = FLOW_FREE;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (epoch == 0) begin
          mode = flow_mode_e'($urandom_range(0, 2));
          epoch = $urandom_range(50, 200);
        end
        epoch--;
        if (stall_left > 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          case (mode)
            FLOW_SPARSE: if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
            FLOW_HEAVY: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 12);
            default: ;
          endcase
        end
      end
    end
  end

  task automatic set_register(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== val) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, idx, val, prdata);
      config_errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    replies.set_register(idx, val);
  endtask

  task automatic configure(input logic [7:0] unit, input logic [15:0] first,
                           input logic [15:0] limit);
    set_register(REG_UNIT_ID, {24'd0, unit});
    set_register(REG_FIRST_ADDR, {16'd0, first});
    set_register(REG_VALUE_LIMIT, {16'd0, limit});
    settings_run++;
  endtask

  task automatic put16(input logic [15:0] v);
    frame_buf.push_back(v[15:8]);
    frame_buf.push_back(v[7:0]);
  endtask

  // mbap header plus function code; length is patched when the frame is closed
  task automatic begin_request(input logic [7:0] unit, input logic [7:0] func);
    frame_buf.delete();
    put16(16'($urandom));
    put16(16'h0000);
    put16(16'h0000);
    frame_buf.push_back(unit);
    frame_buf.push_back(func);
  endtask

  task automatic build_write(input int unsigned start, input int unsigned qty,
                             input int unsigned bcount, input int nwords, input int over_word);
    int k;
    logic [15:0] v;
    begin_request(replies.unit_id_q, FUNC_WRITE_MULTI);
    put16(start[15:0]);
    put16(qty[15:0]);
    frame_buf.push_back(bcount[7:0]);
    for (k = 0; k < nwords; k++) begin
      v = 16'($urandom_range(0, replies.value_cap));
      if (k == over_word) v = 16'($urandom_range(replies.value_cap + 1, 16'hFFFF));
      put16(v);
    end
  endtask

  task automatic end_request(input int skew, input bit fix_len);
    int k, len;
    frame_in_t it;
    len = frame_buf.size() - int'(MBAP_LEN) + skew;
    if (fix_len && frame_buf.size() > 5) begin
      frame_buf[4] = len[15:8];
      frame_buf[5] = len[7:0];
    end
    for (k = 0; k < frame_buf.size(); k++) begin
      it.frame_byte = frame_buf[k];
      it.frame_last = (k == frame_buf.size() - 1);
      req_q.push_back(it);
    end
    frames_built++;
  endtask

  task automatic queue_random_request();
    int unsigned kind, qty, start, top, n;
    int skew;
    logic [7:0] func;
    kind = $urandom_range(0, 99);
    qty = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NUM_REGS) : $urandom_range(1, 3);
    top = replies.base_addr + NUM_REGS;
    start = replies.base_addr + $urandom_range(0, NUM_REGS - qty);
    if (start > 16'hFFFF) start = replies.base_addr;
    skew = 0;
    if (kind < 50) begin
      build_write(start, qty, 2 * qty, qty, -1);
    end else if (kind < 58) begin
      build_write(start, qty, 2 * qty, qty,
                  (replies.value_cap == 16'hFFFF) ? -1 : int'($urandom_range(0, qty - 1)));
    end else if (kind < 66) begin
      case ($urandom_range(0, 2))
        0: build_write(start, 0, 0, 0, -1);
        1: begin
          n = $urandom_range(NUM_REGS + 1, 16'hFFFF);
          build_write(start, n, 2 * n, NUM_REGS, -1);
        end
        default: build_write(start, qty, 2 * qty + $urandom_range(1, 5), qty, -1);
      endcase
    end else if (kind < 74) begin
      if ($urandom_range(0, 1) == 0 && replies.base_addr != 0)
        build_write($urandom_range(0, replies.base_addr - 1), qty, 2 * qty, qty, -1);
      else
        build_write(top - qty + $urandom_range(1, NUM_REGS), qty, 2 * qty, qty, -1);
    end else if (kind < 80) begin
      func = 8'($urandom_range(0, 255));
      if (func == FUNC_WRITE_MULTI) func = 8'h03;
      begin_request(replies.unit_id_q, func);
      repeat ($urandom_range(0, 6)) frame_buf.push_back(8'($urandom));
    end else if (kind < 86) begin
      // data shorter than announced, or running past the staging store
      build_write(start, qty, 2 * qty, $urandom_range(0, qty + 6), -1);
      if ($urandom_range(0, 1) == 0) frame_buf.push_back(8'($urandom));
    end else if (kind < 92) begin
      build_write(start, qty, 2 * qty, qty, -1);
      case ($urandom_range(0, 2))
        0: frame_buf[$urandom_range(2, 3)] = 8'($urandom_range(1, 255));
        1: frame_buf[6] = replies.unit_id_q + 8'($urandom_range(1, 255));
        default: skew = ($urandom_range(0, 1) == 0) ? -1 : int'($urandom_range(1, 4));
      endcase
    end else begin
      frame_buf.delete();
      repeat ((kind < 96) ? $urandom_range(1, 7) : $urandom_range(8, 30))
        frame_buf.push_back(8'($urandom));
      end_request(0, 1'b0);
      return;
    end
    end_request(skew, 1'b1);
  endtask

  task automatic queue_random_requests(input int budget);
    int base;
    base = req_q.size();
    while (req_q.size() - base < budget) queue_random_request();
  endtask

  // every check under the reset settings: unit 1, window 16..23, limit 1023
  task automatic queue_directed_requests();
    build_write(16, 1, 2, 1, -1);
    frame_buf[0] = 8'h00;
    frame_buf[1] = 8'h00;
    end_request(0, 1'b1);
    build_write(16, 8, 16, 8, -1);
    frame_buf[0] = 8'hFF;
    frame_buf[1] = 8'hFF;
    frame_buf[13] = 8'h03;
    frame_buf[14] = 8'hFF;
    end_request(0, 1'b1);
    build_write(23, 1, 2, 1, -1); end_request(0, 1'b1);
    build_write(23, 2, 4, 2, -1); end_request(0, 1'b1);
    build_write(15, 1, 2, 1, -1); end_request(0, 1'b1);
    build_write(24, 1, 2, 1, -1); end_request(0, 1'b1);
    build_write(16, 0, 0, 0, -1); end_request(0, 1'b1);
    build_write(16, 9, 18, 9, -1); end_request(0, 1'b1);
    build_write(16, 2, 3, 2, -1); end_request(0, 1'b1);
    build_write(16, 3, 6, 3, 1); end_request(0, 1'b1);
    begin_request(replies.unit_id_q, 8'h03);
    put16(16'h0010);
    put16(16'h0001);
    end_request(0, 1'b1);
    // bare eight-byte frames: missing header bytes read as zero
    begin_request(replies.unit_id_q, 8'hFF); end_request(0, 1'b1);
    begin_request(replies.unit_id_q, FUNC_WRITE_MULTI); end_request(0, 1'b1);
    // short frames
    begin_request(replies.unit_id_q, FUNC_WRITE_MULTI);
    void'(frame_buf.pop_back());
    end_request(0, 1'b1);
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    end_request(0, 1'b0);
    // header checks
    build_write(16, 1, 2, 1, -1); frame_buf[2] = 8'h80; end_request(0, 1'b1);
    build_write(16, 1, 2, 1, -1); frame_buf[3] = 8'h01; end_request(0, 1'b1);
    build_write(16, 1, 2, 1, -1); frame_buf[6] = 8'h02; end_request(0, 1'b1);
    build_write(16, 1, 2, 1, -1); end_request(1, 1'b1);
    build_write(16, 1, 2, 1, -1); end_request(-1, 1'b1);
    // second word only half sent
    build_write(16, 2, 4, 1, -1); frame_buf.push_back(8'h03); end_request(0, 1'b1);
    build_write(17, 1, 2, 12, -1); end_request(0, 1'b1);
    // longest accepted frame and one past it
    build_write(16, 1, 2, 1, -1);
    while (frame_buf.size() < MAX_FRAME_LEN) frame_buf.push_back(8'($urandom));
    end_request(0, 1'b1);
    build_write(16, 1, 2, 1, -1);
    while (frame_buf.size() < MAX_FRAME_LEN + 1) frame_buf.push_back(8'($urandom));
    end_request(0, 1'b1);
  endtask

  task automatic push_requests();
    int burst_left, gap;
    burst_left = 0;
    while (req_q.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      in_valid_i <= 1'b1;
      in_data_i <= req_q[0];
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      replies.absorb_request_byte(req_q.pop_front());
      sent_bytes++;
      burst_left--;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic run_phase();
    push_requests();
    while (replies.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int k;
    replies = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    queue_directed_requests();
    run_phase();

    configure(8'd0, 16'd0, 16'd0);
    build_write(0, 8, 16, 8, -1); end_request(0, 1'b1);
    build_write(0, 1, 2, 1, 0); end_request(0, 1'b1);
    queue_random_requests(RANDOM_BYTES);
    run_phase();

    // window at the top of the address space: start plus quantity must not wrap
    configure(8'hFF, 16'hFFFF, 16'hFFFF);
    build_write(16'hFFFF, 2, 4, 2, -1); end_request(0, 1'b1);
    build_write(16'hFFFF, 8, 16, 8, -1); end_request(0, 1'b1);
    build_write(16'hFFFE, 1, 2, 1, -1); end_request(0, 1'b1);
    queue_random_requests(RANDOM_BYTES);
    run_phase();

    configure(8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hFFF0)),
              16'($urandom_range(1, 16'hFFFE)));
    queue_random_requests(RANDOM_BYTES);
    run_phase();

    configure(UNIT_ID_RST, FIRST_ADDR_RST, VALUE_LIMIT_RST);
    queue_random_requests(RANDOM_BYTES);
    run_phase();

    // response side held off so the job queue fills and the parser stalls
    hold_request = 1'b1;
    for (k = 0; k < 6; k++) begin
      build_write(16 + k % 4, 1 + k % 2, 2 + 2 * (k % 2), 1 + k % 2, -1);
      end_request(0, 1'b1);
    end
    run_phase();

    for (k = 0; k < replies.pending(); k++)
      $display("%0t: response byte %h last %b never arrived", $time,
               replies.replies_due[k].response_byte, replies.replies_due[k].response_last);
    $display("covered %0d request bytes in %0d frames over %0d settings, %0d frames dropped",
             sent_bytes, frames_built, settings_run + 1, replies.frames_dropped);
    $display("answers: %0d writes, exceptions func %0d addr %0d qty %0d value %0d",
             replies.answers_by_code[EXC_NONE], replies.answers_by_code[EXC_ILLEGAL_FUNC],
             replies.answers_by_code[EXC_ILLEGAL_ADDR], replies.answers_by_code[EXC_ILLEGAL_QTY],
             replies.answers_by_code[EXC_ILLEGAL_VALUE]);
    if (replies.mismatches == 0 && replies.pending() == 0 && config_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
